// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the run extractor rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define GBRE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked property that must also hold during reset
`define GBRE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gbre_pkg.sv
// ---------------------------------------------------------------------------
// gbre_pkg
// Shared constants and types of the grid blocking run extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package gbre_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_DIM_W  = 7;
   localparam int CODE_W     = 8;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_GRID_COLUMNS    = 3'd0;
   localparam csr_index_type CSR_GRID_ROWS       = 3'd1;
   localparam csr_index_type CSR_BLOCKING_CODE_A = 3'd2;
   localparam csr_index_type CSR_BLOCKING_CODE_B = 3'd3;
   localparam csr_index_type CSR_BLOCKING_CODE_C = 3'd4;

   localparam logic [CSR_DIM_W-1:0] GRID_DIM_RESET = 7'd64;

   // result field widths
   localparam int COL_FIELD_W = 6;
   localparam int ROW_FIELD_W = 6;
   localparam int LEN_FIELD_W = 7;

   // queue depths (powers of two)
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_CNT_W       = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                   is_vertical;
      logic [COL_FIELD_W-1:0] start_column;
      logic [ROW_FIELD_W-1:0] start_row;
      logic [LEN_FIELD_W-1:0] run_length;
      logic                   last_of_item;
   } rsp_type;

   // up to two results written per cell
   typedef struct packed {
      logic    push_first;
      logic    push_second;
      rsp_type first;
      rsp_type second;
   } rsp_write_type;

endpackage

`default_nettype wire

// File: rtl/core/gbre_cmd_queue.sv
// ---------------------------------------------------------------------------
// gbre_cmd_queue
// Short queue of classified cells between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbre_cmd_queue
   import gbre_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  valid,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head
);

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(CMD_QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `GBRE_ASSERT(a_cmd_count_bound, clock, reset, count_ff <= CNT_W'(CMD_QUEUE_DEPTH), "cmd queue count beyond depth")

endmodule

`default_nettype wire

// File: rtl/core/gbre_front.sv
// ---------------------------------------------------------------------------
// gbre_front
// Configuration registers, raster position counters and cell classification.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbre_front
   import gbre_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  push,
   input  wire logic [CODE_W-1:0]     req_cell_code,
   input  wire logic                  queue_full,
   output logic                       cmd_push,
   output logic [2+$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS):0] cmd_data,
   output logic                       restart
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CDW   = (COL_W + 1 > CSR_DIM_W) ? COL_W + 1 : CSR_DIM_W;
   localparam int RDW   = (ROW_W + 1 > CSR_DIM_W) ? ROW_W + 1 : CSR_DIM_W;

   typedef struct packed {
      logic             blocking;
      logic             last_col;
      logic             last_row;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cell_cmd_type;

   logic [CSR_DIM_W-1:0] grid_columns_ff;
   logic [CSR_DIM_W-1:0] grid_rows_ff;
   logic [CODE_W-1:0]    code_a_ff;
   logic [CODE_W-1:0]    code_b_ff;
   logic [CODE_W-1:0]    code_c_ff;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [CDW-1:0]       cols_ext;
   logic [CDW-1:0]       cols_eff;
   logic [RDW-1:0]       rows_ext;
   logic [RDW-1:0]       rows_eff;
   logic                 last_col;
   logic                 last_row;
   logic                 accept;
   cell_cmd_type         cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_DIM_RESET;
         grid_rows_ff    <= GRID_DIM_RESET;
         code_a_ff       <= '0;
         code_b_ff       <= '0;
         code_c_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS:    grid_columns_ff <= csr_wdata[CSR_DIM_W-1:0];
            CSR_GRID_ROWS:       grid_rows_ff    <= csr_wdata[CSR_DIM_W-1:0];
            CSR_BLOCKING_CODE_A: code_a_ff       <= csr_wdata;
            CSR_BLOCKING_CODE_B: code_b_ff       <= csr_wdata;
            CSR_BLOCKING_CODE_C: code_c_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a geometry write starts a fresh grid
   assign restart = csr_we && (csr_index == CSR_GRID_COLUMNS || csr_index == CSR_GRID_ROWS);

   // effective geometry: zero acts as one, large values saturate
   always_comb begin
      cols_ext = CDW'(grid_columns_ff);
      rows_ext = RDW'(grid_rows_ff);
      priority if (grid_columns_ff == '0) cols_eff = CDW'(1);
      else if (cols_ext > CDW'(MAX_COLUMNS)) cols_eff = CDW'(MAX_COLUMNS);
      else cols_eff = cols_ext;
      priority if (grid_rows_ff == '0) rows_eff = RDW'(1);
      else if (rows_ext > RDW'(MAX_ROWS)) rows_eff = RDW'(MAX_ROWS);
      else rows_eff = rows_ext;
   end

   assign last_col = (CDW'(col_ff) + CDW'(1)) >= cols_eff;
   assign last_row = (RDW'(row_ff) + RDW'(1)) >= rows_eff;
   assign accept   = push && !queue_full;

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // classification
   always_comb begin
      cmd.blocking = (req_cell_code == code_a_ff) || (req_cell_code == code_b_ff) ||
                     (req_cell_code == code_c_ff);
      cmd.last_col = last_col;
      cmd.last_row = last_row;
      cmd.col      = col_ff;
      cmd.row      = row_ff;
   end

   assign cmd_push = accept;
   assign cmd_data = cmd;

   `GBRE_ASSERT(a_col_in_grid, clock, reset, CDW'(col_ff) < cols_eff, "column counter outside grid")
   `GBRE_ASSERT(a_row_in_grid, clock, reset, RDW'(row_ff) < rows_eff, "row counter outside grid")

endmodule

`default_nettype wire

// File: rtl/core/gbre_back.sv
// ---------------------------------------------------------------------------
// gbre_back
// Run tracking: horizontal run state, line memory of the row above and
// result generation.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbre_back
   import gbre_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 restart,
   input  wire logic                 cmd_valid,
   input  wire logic [2+$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS):0] cmd_data,
   output logic                      cmd_pop,
   input  wire logic [RSP_CNT_W-1:0] rsp_free,
   output rsp_write_type             rsp_wr
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int MEM_W = 1 + ROW_W;

   typedef struct packed {
      logic             blocking;
      logic             last_col;
      logic             last_row;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cell_cmd_type;

   cell_cmd_type     next_cmd;
   cell_cmd_type     s1_cmd_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_fire;

   // line memory: blocking bit and vertical start row per column
   logic [MEM_W-1:0] line_mem [MAX_COLUMNS];
   logic [MEM_W-1:0] rd_word_ff;
   logic [MEM_W-1:0] wr_word;
   logic             bypass;

   // horizontal run state
   logic             h_active_ff, h_active_in;
   logic [COL_W-1:0] h_col_ff, h_col_in;
   logic             h_above_ff, h_above_in;

   logic             b;
   logic             above;
   logic             act;
   logic             h_end;
   logic             h_emit;
   logic [COL_W:0]   h_len;
   logic [ROW_W-1:0] v_start;
   logic             v_end;
   logic             v_emit;
   logic [ROW_W:0]   v_len;
   logic [1:0]       n_results;

   logic [COL_W+COL_FIELD_W-1:0] h_col_wide;
   logic [COL_W+COL_FIELD_W-1:0] v_col_wide;
   logic [ROW_W+ROW_FIELD_W-1:0] h_row_wide;
   logic [ROW_W+ROW_FIELD_W-1:0] v_row_wide;
   logic [COL_W+LEN_FIELD_W:0]   h_len_wide;
   logic [ROW_W+LEN_FIELD_W:0]   v_len_wide;
   rsp_type                      h_rsp;
   rsp_type                      v_rsp;

   assign next_cmd = cmd_data;

   // horizontal runs
   always_comb begin
      b           = s1_cmd_ff.blocking;
      above       = rd_word_ff[MEM_W-1] && (s1_cmd_ff.row != '0);
      act         = h_active_ff || b;
      h_col_in    = h_active_ff ? h_col_ff : s1_cmd_ff.col;
      h_above_in  = h_active_ff ? h_above_ff : above;
      h_end       = act && (!b || s1_cmd_ff.last_col);
      h_len       = (b ? {1'b0, s1_cmd_ff.col} + (COL_W+1)'(1) : {1'b0, s1_cmd_ff.col}) -
                    {1'b0, h_col_in};
      h_emit      = h_end && ((h_len > (COL_W+1)'(1)) || !h_above_in);
      h_active_in = act && !h_end;
   end

   // vertical runs
   always_comb begin
      v_start = (b && !above) ? s1_cmd_ff.row : rd_word_ff[ROW_W-1:0];
      v_end   = (above && !b) || (b && s1_cmd_ff.last_row);
      v_len   = (b ? {1'b0, s1_cmd_ff.row} + (ROW_W+1)'(1) : {1'b0, s1_cmd_ff.row}) -
                {1'b0, v_start};
      v_emit  = v_end && (v_len > (ROW_W+1)'(1));
      wr_word = {b && !s1_cmd_ff.last_row, v_start};
   end

   // result formatting, fields taken modulo their widths
   always_comb begin
      h_col_wide = {{COL_FIELD_W{1'b0}}, h_col_in};
      v_col_wide = {{COL_FIELD_W{1'b0}}, s1_cmd_ff.col};
      h_row_wide = {{ROW_FIELD_W{1'b0}}, s1_cmd_ff.row};
      v_row_wide = {{ROW_FIELD_W{1'b0}}, v_start};
      h_len_wide = {{LEN_FIELD_W{1'b0}}, h_len};
      v_len_wide = {{LEN_FIELD_W{1'b0}}, v_len};

      h_rsp.is_vertical  = 1'b0;
      h_rsp.start_column = h_col_wide[COL_FIELD_W-1:0];
      h_rsp.start_row    = h_row_wide[ROW_FIELD_W-1:0];
      h_rsp.run_length   = h_len_wide[LEN_FIELD_W-1:0];
      h_rsp.last_of_item = !v_emit;

      v_rsp.is_vertical  = 1'b1;
      v_rsp.start_column = v_col_wide[COL_FIELD_W-1:0];
      v_rsp.start_row    = v_row_wide[ROW_FIELD_W-1:0];
      v_rsp.run_length   = v_len_wide[LEN_FIELD_W-1:0];
      v_rsp.last_of_item = 1'b1;
   end

   // stage completes once the result queue has room for what it produces
   assign n_results = {1'b0, h_emit} + {1'b0, v_emit};
   assign s1_fire   = s1_valid_ff && (RSP_CNT_W'(n_results) <= rsp_free);
   assign cmd_pop   = cmd_valid && (!s1_valid_ff || s1_fire);

   always_comb begin
      rsp_wr.push_first  = s1_fire && (h_emit || v_emit);
      rsp_wr.push_second = s1_fire && h_emit && v_emit;
      rsp_wr.first       = h_emit ? h_rsp : v_rsp;
      rsp_wr.second      = v_rsp;
   end

   // stage register
   always_comb begin
      priority if (cmd_pop) s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_cmd_ff <= next_cmd;
      end
   end

   // horizontal state update
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         h_active_ff <= 1'b0;
      end else if (s1_fire) begin
         h_active_ff <= h_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         h_col_ff   <= h_col_in;
         h_above_ff <= h_above_in;
      end
   end

   // line memory write, and registered read with forwarding for one-column grids
   assign bypass = s1_fire && (next_cmd.col == s1_cmd_ff.col);

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_mem[s1_cmd_ff.col] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_word_ff <= bypass ? wr_word : line_mem[next_cmd.col];
      end
   end

   `GBRE_ASSERT(a_row_end_closes_run, clock, reset, s1_fire && s1_cmd_ff.last_col |=> !h_active_ff, "horizontal run left open past row end")
   `GBRE_ASSERT(a_h_len_nonzero, clock, reset, s1_fire && h_emit |-> h_len != '0, "horizontal run of zero length")

endmodule

`default_nettype wire

// File: rtl/core/gbre_rsp_queue.sv
// ---------------------------------------------------------------------------
// gbre_rsp_queue
// Result queue taking up to two results per cycle and giving one.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbre_rsp_queue
   import gbre_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rsp_write_type rsp_wr,
   output logic [RSP_CNT_W-1:0] free,
   output logic               empty,
   input  wire logic          pop,
   output rsp_type            head
);

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);

   rsp_type              slot_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_CNT_W-1:0] n_push;
   logic                 do_pop;

   assign empty  = (count_ff == '0);
   assign free   = RSP_CNT_W'(RSP_QUEUE_DEPTH) - count_ff;
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;
   assign n_push = RSP_CNT_W'(rsp_wr.push_first) + RSP_CNT_W'(rsp_wr.push_second);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + n_push - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, second result goes in the slot after the first
   always_ff @(posedge clock) begin
      if (rsp_wr.push_first) begin
         slot_ff[wr_ptr_ff] <= rsp_wr.first;
      end
      if (rsp_wr.push_second) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= rsp_wr.second;
      end
   end

   `GBRE_ASSERT(a_rsp_count_bound, clock, reset, count_ff <= RSP_CNT_W'(RSP_QUEUE_DEPTH), "result queue count beyond depth")
   `GBRE_ASSERT(a_second_needs_first, clock, reset, rsp_wr.push_second |-> rsp_wr.push_first, "second result written without first")

endmodule

`default_nettype wire

// File: rtl/core/grid_blocking_run_extractor.sv
// ---------------------------------------------------------------------------
// grid_blocking_run_extractor
// Extracts horizontal and vertical runs of blocking cells from a raster grid.
// ---------------------------------------------------------------------------
// Cells enter one per cycle in raster order through push/full; a cell blocks
// when its code matches any of the three blocking codes. Each run comes out
// through empty/pop as start column, start row, length and direction at the
// cell that ends it, so runs appear in order of their end, with the horizontal
// result first when one cell closes both kinds; last_of_item marks the final
// result of a cell. Throughput is one cell per clock: the back end handles a
// cell per cycle and only waits when the result queue lacks room for what the
// current cell produces, with room counted before this cycle's pop. That
// happens when the receiver holds off pop, or when cells close runs faster
// than one result per cycle, as around a cell that closes two runs. A cell
// passes the command queue, stage register and result queue. The row above
// is held in a line memory of MAX_COLUMNS entries, read as the cell enters the
// stage register; it needs no clearing after reset because cells of row 0
// never look at it. Writing grid_columns or grid_rows restarts the grid at
// row 0, column 0 and must only be done while no cell or result is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grid_blocking_run_extractor
   import gbre_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // cells
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [CODE_W-1:0]      req_cell_code,
   // runs
   output logic                        empty,
   input  wire logic                   pop,
   output logic                        rsp_is_vertical,
   output logic [COL_FIELD_W-1:0]      rsp_start_column,
   output logic [ROW_FIELD_W-1:0]      rsp_start_row,
   output logic [LEN_FIELD_W-1:0]      rsp_run_length,
   output logic                        rsp_last_of_item
);

   localparam int CMD_W = 3 + $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);

   logic                 cmd_push;
   logic [CMD_W-1:0]     cmd_in_data;
   logic                 cmd_full;
   logic                 cmd_valid;
   logic                 cmd_pop;
   logic [CMD_W-1:0]     cmd_head;
   logic                 restart;
   logic [RSP_CNT_W-1:0] rsp_free;
   rsp_write_type        rsp_wr;
   rsp_type              rsp_head;
   logic                 rsp_empty;

   // front end: configuration, position and classification
   gbre_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .push          (push),
      .req_cell_code (req_cell_code),
      .queue_full    (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_in_data),
      .restart       (restart)
   );

   // decoupling queue
   gbre_cmd_queue #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .valid     (cmd_valid),
      .pop       (cmd_pop),
      .head      (cmd_head)
   );

   // back end: run tracking
   gbre_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_free  (rsp_free),
      .rsp_wr    (rsp_wr)
   );

   // result queue
   gbre_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .rsp_wr (rsp_wr),
      .free   (rsp_free),
      .empty  (rsp_empty),
      .pop    (pop),
      .head   (rsp_head)
   );

   assign full             = cmd_full;
   assign empty            = rsp_empty;
   assign rsp_is_vertical  = rsp_head.is_vertical;
   assign rsp_start_column = rsp_head.start_column;
   assign rsp_start_row    = rsp_head.start_row;
   assign rsp_run_length   = rsp_head.run_length;
   assign rsp_last_of_item = rsp_head.last_of_item;

   `GBRE_ASSERT(a_pop_stalls_on_empty, clock, reset, $past(!cmd_valid) && !cmd_valid |-> !$past(cmd_pop), "back end popped an empty queue")
   `GBRE_ASSERT(a_result_length_nonzero, clock, reset, !rsp_empty |-> rsp_run_length != '0, "result with zero length")

endmodule

`default_nettype wire

// File: bench/grid_blocking_run_extractor_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// grid_blocking_run_extractor_test
// Self-checking bench for the blocking run extractor. Cell codes go in through
// the push/full queue port and runs come back through empty/pop. A bench-side
// model of the raster walk predicts every run, in order, and each popped
// transaction is compared field by field. A short directed table covers reset
// state, clamped geometry, restarts and a cell that closes two runs. Random
// phases then vary geometry, codes, run density and idling on both sides.
// ---------------------------------------------------------------------------

module grid_blocking_run_extractor_test;
   import gbre_pkg::*;

   localparam int GRID_LIMIT   = 64;     // matches the block's default size
   localparam int DRAIN_CYCLES = 8;      // wait after the last expected run, for cells that close none
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_ITEMS  = 60;
   localparam int PREDICTED    = -1;     // row result comes from the bench model

   localparam rsp_type NO_RUN     = '0;
   localparam rsp_type SINGLE_RUN = rsp_type'{1'b0, 6'd0, 6'd0, 7'd1, 1'b1};

   typedef enum {ACT_CELL, ACT_WRITE} plan_action_type;

   typedef struct {
      plan_action_type action;
      csr_index_type   index;
      logic [7:0]      value;
      int              typed_count;
      rsp_type         typed_run;
   } plan_row_type;

   typedef struct {
      int      typed_count;
      rsp_type typed_run;
   } cell_note_type;

   typedef struct {
      logic [7:0] columns;
      logic [7:0] rows;
      logic [7:0] code_a;
      logic [7:0] code_b;
      logic [7:0] code_c;
      int         density;
      int         noise;
      int         count;
      int         send_odds;
      int         rsp_odds;
      bit         hold;
   } phase_type;

   // directed table
   localparam int PLAN_ROWS = 26;
   plan_row_type directed_plan [PLAN_ROWS] = '{
      // after reset every code is 0, so code 0 opens a run and code FF closes it
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, 0,         NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, 1,         SINGLE_RUN},
      // zero geometry acts as a 1 x 1 grid
      '{ACT_WRITE, CSR_GRID_COLUMNS,    8'h00, PREDICTED, NO_RUN},
      '{ACT_WRITE, CSR_GRID_ROWS,       8'h00, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, 1,         SINGLE_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h01, 0,         NO_RUN},
      '{ACT_WRITE, CSR_BLOCKING_CODE_A, 8'hFF, PREDICTED, NO_RUN},
      '{ACT_WRITE, CSR_BLOCKING_CODE_B, 8'hAA, PREDICTED, NO_RUN},
      '{ACT_WRITE, CSR_BLOCKING_CODE_C, 8'h55, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, 0,         NO_RUN},
      // oversized column count clamps to the full width
      '{ACT_WRITE, CSR_GRID_COLUMNS,    8'h7F, PREDICTED, NO_RUN},
      '{ACT_WRITE, CSR_GRID_ROWS,       8'h03, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hAA, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h55, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN},
      // geometry rewritten with a run still open
      '{ACT_WRITE, CSR_GRID_COLUMNS,    8'h03, PREDICTED, NO_RUN},
      // 3 x 3 grid, last cell closes a horizontal and a vertical run
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hAA, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h55, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'h00, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN},
      '{ACT_CELL,  CSR_GRID_COLUMNS,    8'hFF, PREDICTED, NO_RUN}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   push;
   logic                   full;
   logic [CODE_W-1:0]      req_cell_code;
   logic                   empty;
   logic                   pop;
   logic                   rsp_is_vertical;
   logic [COL_FIELD_W-1:0] rsp_start_column;
   logic [ROW_FIELD_W-1:0] rsp_start_row;
   logic [LEN_FIELD_W-1:0] rsp_run_length;
   logic                   rsp_last_of_item;

   // grid model: settings and raster state
   logic [6:0] columns_setting = 7'd64;
   logic [6:0] rows_setting    = 7'd64;
   logic [7:0] code_a_setting  = 8'h00;
   logic [7:0] code_b_setting  = 8'h00;
   logic [7:0] code_c_setting  = 8'h00;
   int         row_now;
   int         column_now;
   bit         above_blocking [GRID_LIMIT];
   int         vertical_start [GRID_LIMIT];
   bit         run_open;
   int         run_start_column;
   bit         run_start_covered;

   rsp_type       expected_runs [$];
   cell_note_type cell_notes [$];

   int send_gap_odds;
   int rsp_gap_odds;
   bit hold_request;
   int cycle_count;
   int failures;
   int cells_sent;
   int runs_checked;
   int vertical_runs;
   int double_cells;
   int input_stalls;
   int settings_used;

   grid_blocking_run_extractor dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .full             (full),
      .req_cell_code    (req_cell_code),
      .empty            (empty),
      .pop              (pop),
      .rsp_is_vertical  (rsp_is_vertical),
      .rsp_start_column (rsp_start_column),
      .rsp_start_row    (rsp_start_row),
      .rsp_run_length   (rsp_run_length),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // geometry value as the block uses it
   function automatic int effective_span(logic [6:0] setting);
      if (setting == 7'd0) return 1;
      if (setting > GRID_LIMIT) return GRID_LIMIT;
      return setting;
   endfunction

   function automatic void clear_grid();
      row_now           = 0;
      column_now        = 0;
      run_open          = 1'b0;
      run_start_column  = 0;
      run_start_covered = 1'b0;
      for (int i = 0; i < GRID_LIMIT; i++) begin
         above_blocking[i] = 1'b0;
         vertical_start[i] = 0;
      end
   endfunction

   // one cell through the raster walk; returns the number of runs it emits
   function automatic int step_grid(input logic [7:0] code, output rsp_type runs [2]);
      int cols;
      int rows;
      int c;
      int r;
      int len;
      int n;
      bit blocks;
      bit above;
      bit last_col;
      bit last_row;
      cols     = effective_span(columns_setting);
      rows     = effective_span(rows_setting);
      c        = column_now;
      r        = row_now;
      blocks   = (code == code_a_setting) || (code == code_b_setting) ||
                 (code == code_c_setting);
      last_col = (c + 1 >= cols);
      last_row = (r + 1 >= rows);
      above    = above_blocking[c];
      n        = 0;
      runs[0]  = NO_RUN;
      runs[1]  = NO_RUN;

      // horizontal run, dropped when single and covered from above
      if (blocks && !run_open) begin
         run_open          = 1'b1;
         run_start_column  = c;
         run_start_covered = above;
      end
      if (run_open && (!blocks || last_col)) begin
         len = (blocks ? c + 1 : c) - run_start_column;
         if (len > 1 || !run_start_covered) begin
            runs[n] = rsp_type'{1'b0, 6'(run_start_column), 6'(r), 7'(len), 1'b0};
            n++;
         end
         run_open = 1'b0;
      end

      // vertical run, only when longer than one cell
      if (blocks && !above) vertical_start[c] = r;
      if ((above && !blocks) || (blocks && last_row)) begin
         len = (blocks ? r + 1 : r) - vertical_start[c];
         if (len > 1) begin
            runs[n] = rsp_type'{1'b1, 6'(c), 6'(vertical_start[c]), 7'(len), 1'b0};
            n++;
         end
      end
      above_blocking[c] = blocks && !last_row;

      // raster advance, wrapping into a fresh grid
      if (last_col) begin
         column_now = 0;
         row_now    = last_row ? 0 : r + 1;
      end else begin
         column_now = c + 1;
      end

      if (n > 0) runs[n-1].last_of_item = 1'b1;
      return n;
   endfunction

   function automatic void report_field(string name, logic [6:0] want, logic [6:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endfunction

   // wait for every expected run, then let cells that close none drain
   task automatic wait_idle();
      do @(posedge clock); while (expected_runs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type index, logic [7:0] value);
      push <= 1'b0;
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_GRID_COLUMNS: begin
            columns_setting = value[6:0];
            clear_grid();
         end
         CSR_GRID_ROWS: begin
            rows_setting = value[6:0];
            clear_grid();
         end
         CSR_BLOCKING_CODE_A: code_a_setting = value;
         CSR_BLOCKING_CODE_B: code_b_setting = value;
         CSR_BLOCKING_CODE_C: code_c_setting = value;
         default: ;
      endcase
   endtask

   // offer one cell, with an optional gap before it
   task automatic send_cell(logic [7:0] code, int typed_count, rsp_type typed_run);
      if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      cell_notes.insert(cell_notes.size(), cell_note_type'{typed_count, typed_run});
      push          <= 1'b1;
      req_cell_code <= code;
      do @(posedge clock); while (full);
      cells_sent++;
   endtask

   function automatic logic [7:0] pick_code(phase_type ph);
      logic [7:0] code;
      if ($urandom_range(0, 99) < ph.noise) return 8'($urandom_range(0, 255));
      if ($urandom_range(1, 100) <= ph.density) begin
         case ($urandom_range(0, 2))
            0:       return ph.code_a;
            1:       return ph.code_b;
            default: return ph.code_c;
         endcase
      end
      do code = 8'($urandom_range(0, 255));
      while (code == ph.code_a || code == ph.code_b || code == ph.code_c);
      return code;
   endfunction

   function automatic logic [7:0] pick_dimension();
      case ($urandom_range(0, 19))
         0:       return 8'd0;
         1:       return 8'($urandom_range(65, 255));
         2, 3:    return 8'($urandom_range(9, 64));
         default: return 8'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic phase_type random_phase(int count, bit quiet);
      phase_type ph;
      ph.columns = pick_dimension();
      ph.rows    = pick_dimension();
      ph.code_a  = 8'($urandom_range(0, 255));
      ph.code_b  = ($urandom_range(0, 3) == 0) ? ph.code_a : 8'($urandom_range(0, 255));
      ph.code_c  = ($urandom_range(0, 3) == 0) ? ph.code_b : 8'($urandom_range(0, 255));
      ph.density = $urandom_range(20, 90);
      ph.noise   = 8;
      ph.count   = count;
      ph.send_odds = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      ph.rsp_odds  = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      ph.hold    = 1'b0;
      return ph;
   endfunction

   task automatic run_phase(phase_type ph);
      write_register(CSR_GRID_COLUMNS, ph.columns);
      write_register(CSR_GRID_ROWS, ph.rows);
      write_register(CSR_BLOCKING_CODE_A, ph.code_a);
      write_register(CSR_BLOCKING_CODE_B, ph.code_b);
      write_register(CSR_BLOCKING_CODE_C, ph.code_c);
      send_gap_odds = ph.send_odds;
      rsp_gap_odds  = ph.rsp_odds;
      settings_used++;
      if (ph.hold) hold_request = 1'b1;
      for (int i = 0; i < ph.count; i++) send_cell(pick_code(ph), PREDICTED, NO_RUN);
   endtask

   // run drain side: random pauses and one long hold-off
   initial begin
      pop <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_gap_odds != 0 && $urandom_range(1, rsp_gap_odds) == 1) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // check each popped run, predict each accepted cell
   always @(posedge clock) begin
      cell_note_type note;
      rsp_type       want;
      rsp_type       found [2];
      int            n;
      if (reset === 1'b0) begin
         if (pop && !empty) begin
            if (expected_runs.size() == 0) begin
               failures++;
               $display("%0t: run with none expected, expected nothing, actual %0b %0d %0d %0d %0b",
                        $time, rsp_is_vertical, rsp_start_column, rsp_start_row,
                        rsp_run_length, rsp_last_of_item);
            end else begin
               want = expected_runs.pop_front();
               runs_checked++;
               if (want.is_vertical) vertical_runs++;
               if (rsp_is_vertical !== want.is_vertical)
                  report_field("is_vertical", want.is_vertical, rsp_is_vertical);
               if (rsp_start_column !== want.start_column)
                  report_field("start_column", want.start_column, rsp_start_column);
               if (rsp_start_row !== want.start_row)
                  report_field("start_row", want.start_row, rsp_start_row);
               if (rsp_run_length !== want.run_length)
                  report_field("run_length", want.run_length, rsp_run_length);
               if (rsp_last_of_item !== want.last_of_item)
                  report_field("last_of_item", want.last_of_item, rsp_last_of_item);
            end
         end
         if (push && full) input_stalls++;
         if (push && !full) begin
            if (cell_notes.size() != 0) note = cell_notes.pop_front();
            else note = cell_note_type'{PREDICTED, NO_RUN};
            n = step_grid(req_cell_code, found);
            if (n == 2) double_cells++;
            if (note.typed_count == PREDICTED) begin
               for (int i = 0; i < n; i++) expected_runs.insert(expected_runs.size(), found[i]);
            end else if (note.typed_count == 1) begin
               expected_runs.insert(expected_runs.size(), note.typed_run);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // stimulus
   initial begin
      phase_type  ph;
      logic [7:0] same_code;
      int         random_sent;
      reset         <= 1'b1;
      push          <= 1'b0;
      req_cell_code <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_GRID_COLUMNS;
      csr_wdata     <= '0;
      send_gap_odds = 4;
      rsp_gap_odds  = 4;
      hold_request  = 1'b0;
      clear_grid();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      settings_used = 1;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].action == ACT_WRITE)
            write_register(directed_plan[i].index, directed_plan[i].value);
         else
            send_cell(directed_plan[i].value, directed_plan[i].typed_count,
                      directed_plan[i].typed_run);
      end

      // one column of full height, all codes equal: longest vertical run
      same_code = 8'($urandom_range(0, 255));
      ph = '{columns: 8'd1, rows: 8'd64, code_a: same_code, code_b: same_code,
             code_c: same_code, density: 100, noise: 0, count: 64, send_odds: 3,
             rsp_odds: 3, hold: 1'b0};
      run_phase(ph);

      // two full-width rows: a run per cell in the second row, two at its last cell, drain held off
      ph = '{columns: 8'd64, rows: 8'd2, code_a: 8'h00, code_b: 8'hFF,
             code_c: 8'h3C, density: 100, noise: 0, count: 128, send_odds: 0,
             rsp_odds: 2, hold: 1'b1};
      run_phase(ph);
      random_sent = 192;

      while (random_sent < RANDOM_ITEMS - QUIET_ITEMS) begin
         ph = random_phase($urandom_range(20, 50), 1'b0);
         if (ph.count > RANDOM_ITEMS - QUIET_ITEMS - random_sent)
            ph.count = RANDOM_ITEMS - QUIET_ITEMS - random_sent;
         run_phase(ph);
         random_sent += ph.count;
      end

      // closing stretch at full rate on both sides
      run_phase(random_phase(QUIET_ITEMS, 1'b1));
      push <= 1'b0;
      wait_idle();

      $display("covered %0d cells over %0d grid settings, %0d runs checked (%0d vertical)",
               cells_sent, settings_used, runs_checked, vertical_runs);
      $display("%0d cells closed two runs, input stalled for %0d cycles",
               double_cells, input_stalls);
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
